// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define FRGTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define FRGTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/frgts_pkg.sv =====
// Types, constants and character tables of the replay gain tag scanner.
`timescale 1ns / 1ps

package frgts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MARKER,
    PH_HEADER,
    PH_SKIP,
    PH_VLEN,
    PH_VENDOR,
    PH_COUNT,
    PH_CLEN,
    PH_KEY,
    PH_VLEAD,
    PH_VSIGN,
    PH_VINT,
    PH_VFRAC,
    PH_VSTOP,
    PH_DONE
  } phase_t;

  localparam logic [1:0] REASON_DONE       = 2'd0;
  localparam logic [1:0] REASON_NO_COMMENT = 2'd1;
  localparam logic [1:0] REASON_BAD_MARKER = 2'd2;
  localparam logic [1:0] REASON_TRUNCATED  = 2'd3;

  localparam logic [4:0]  KEY_LEN            = 5'd22;
  localparam logic [14:0] GAIN_MAX           = 15'd32767;
  localparam logic [6:0]  VORBIS_COMMENT_TYPE = 7'd4;

  typedef struct packed {
    phase_t        phase;
    logic [4:0]    idx;
    logic          last_blk;
    logic [23:0]   block_rem;
    logic [31:0]   len_acc;
    logic [31:0]   comments_left;
    logic [31:0]   comment_rem;
    logic          key_match;
    logic          val_sign;
    logic [14:0]   val_acc;
    logic [1:0]    frac_seen;
    logic [15:0]   kept_gain;
    logic          kept_found;
  } scan_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       first;
    logic       last;
  } hold_t;

  typedef struct packed {
    logic signed [15:0] gain;
    logic               found;
    logic [1:0]         reason;
  } result_t;

  typedef struct packed {
    logic   emit;
    phase_t phase;
  } parse_status_t;

  function automatic logic [7:0] marker_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = "f";
      2'd1: c = "L";
      2'd2: c = "a";
      2'd3: c = "C";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_char(input logic [4:0] i);
    logic [7:0] c;
    unique case (i)
      5'd0:  c = "R";
      5'd1:  c = "E";
      5'd2:  c = "P";
      5'd3:  c = "L";
      5'd4:  c = "A";
      5'd5:  c = "Y";
      5'd6:  c = "G";
      5'd7:  c = "A";
      5'd8:  c = "I";
      5'd9:  c = "N";
      5'd10: c = "_";
      5'd11: c = "T";
      5'd12: c = "R";
      5'd13: c = "A";
      5'd14: c = "C";
      5'd15: c = "K";
      5'd16: c = "_";
      5'd17: c = "G";
      5'd18: c = "A";
      5'd19: c = "I";
      5'd20: c = "N";
      5'd21: c = "=";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/frgts_in_reg.sv =====
// Input holding register between the byte stream and the parser.
`timescale 1ns / 1ps

module frgts_in_reg
  import frgts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tuser,   // first_byte
  input  logic       in_tlast,   // stream_end
  input  logic       advance,
  output hold_t      hold
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       first_r;
  logic       last_r;
  logic       take;

  // The slot is free when empty or when its item moves on in this cycle.
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r  <= in_tdata;
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  assign hold = '{valid: valid_r, data: data_r, first: first_r, last: last_r};

endmodule

// ===== rtl/core/frgts_parser.sv =====
// Scan state register and the per-byte next-state logic of the tag scanner.
`timescale 1ns / 1ps

module frgts_parser
  import frgts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  hold_t         hold,
  input  logic          advance,
  output parse_status_t status,
  output result_t       result
);

  scan_state_t state_r, st_nxt;
  scan_state_t cur;
  logic [7:0]  b;
  logic [23:0] br_dec;
  logic [31:0] cr_dec;
  logic [4:0]  idx_inc;
  logic [31:0] byte_le;
  logic [31:0] len_le;
  logic [31:0] cnt_le;
  logic [7:0]  k_char;
  logic        k_hit;
  logic        digit;
  logic [3:0]  dval;
  logic [18:0] int_sum;
  logic [14:0] int_sat;
  logic [6:0]  frac_add;
  logic [15:0] frac_sum;
  logic [14:0] frac_sat;
  logic [14:0] num_acc;
  phase_t      num_phase;
  logic        ws;
  logic [15:0] gain_mag;
  logic        emit;
  logic [1:0]  reason;

  assign b = hold.data;

  // A first byte starts from a cleared scan in the marker phase.
  always_comb begin
    cur = state_r;
    if (hold.first) begin
      cur       = '0;
      cur.phase = PH_MARKER;
    end
  end

  assign br_dec  = cur.block_rem - 24'd1;
  assign cr_dec  = cur.comment_rem - 32'd1;
  assign idx_inc = cur.idx + 5'd1;

  // Little-endian fields take the byte at the lane given by the byte index.
  always_comb begin
    unique case (cur.idx[1:0])
      2'd0: byte_le = {24'd0, b};
      2'd1: byte_le = {16'd0, b, 8'd0};
      2'd2: byte_le = {8'd0, b, 16'd0};
      2'd3: byte_le = {b, 24'd0};
    endcase
  end

  assign len_le = cur.len_acc | byte_le;
  assign cnt_le = cur.comments_left | byte_le;

  assign k_char = key_char(cur.idx);
  assign k_hit  = (b == k_char) ||
                  ((k_char >= "A") && (k_char <= "Z") && (b == (k_char + 8'd32)));

  assign digit = (b >= "0") && (b <= "9");
  assign dval  = b[3:0];
  assign ws    = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));

  assign int_sum  = 19'(cur.val_acc) * 19'd10 + 19'(dval) * 19'd100;
  assign int_sat  = (int_sum > 19'(GAIN_MAX)) ? GAIN_MAX : int_sum[14:0];
  assign frac_add = (cur.frac_seen == 2'd0) ? 7'(dval) * 7'd10 : 7'(dval);
  assign frac_sum = 16'(cur.val_acc) + 16'(frac_add);
  assign frac_sat = (frac_sum > 16'(GAIN_MAX)) ? GAIN_MAX : frac_sum[14:0];

  always_comb begin
    num_acc = cur.val_acc;
    if (digit) begin
      num_acc   = int_sat;
      num_phase = PH_VINT;
    end else if (b == ".") begin
      num_phase = PH_VFRAC;
    end else begin
      num_phase = PH_VSTOP;
    end
  end

  always_comb begin
    st_nxt   = cur;
    emit     = 1'b0;
    reason   = REASON_DONE;
    gain_mag = '0;
    unique case (cur.phase)
      PH_MARKER: begin
        if (b != marker_char(cur.idx[1:0])) begin
          emit   = 1'b1;
          reason = REASON_BAD_MARKER;
        end else if (cur.idx[1:0] == 2'd3) begin
          st_nxt.phase   = PH_HEADER;
          st_nxt.idx     = '0;
          st_nxt.len_acc = '0;
        end else begin
          st_nxt.idx = idx_inc;
        end
      end
      PH_HEADER: begin
        st_nxt.len_acc = {cur.len_acc[23:0], b};
        if (cur.idx[1:0] == 2'd3) begin
          st_nxt.last_blk  = cur.len_acc[23];
          st_nxt.block_rem = {cur.len_acc[15:0], b};
          st_nxt.idx       = '0;
          st_nxt.len_acc   = '0;
          if (cur.len_acc[22:16] == VORBIS_COMMENT_TYPE) begin
            if ({cur.len_acc[15:0], b} < 24'd4) begin
              emit = 1'b1;
            end else begin
              st_nxt.phase = PH_VLEN;
            end
          end else if ({cur.len_acc[15:0], b} == 24'd0) begin
            // An empty block that is not the last one leads to the next header.
            if (cur.len_acc[23]) begin
              emit   = 1'b1;
              reason = REASON_NO_COMMENT;
            end
          end else begin
            st_nxt.phase = PH_SKIP;
          end
        end else begin
          st_nxt.idx = idx_inc;
        end
      end
      PH_SKIP: begin
        st_nxt.block_rem = br_dec;
        if (br_dec == 24'd0) begin
          if (cur.last_blk) begin
            emit   = 1'b1;
            reason = REASON_NO_COMMENT;
          end else begin
            st_nxt.phase   = PH_HEADER;
            st_nxt.idx     = '0;
            st_nxt.len_acc = '0;
          end
        end
      end
      PH_VLEN: begin
        st_nxt.block_rem = br_dec;
        st_nxt.len_acc   = len_le;
        st_nxt.idx       = idx_inc;
        if (cur.idx[1:0] == 2'd3) begin
          if (len_le > {8'd0, br_dec}) begin
            emit = 1'b1;
          end else if (len_le == 32'd0) begin
            if (br_dec < 24'd4) begin
              emit = 1'b1;
            end else begin
              st_nxt.phase         = PH_COUNT;
              st_nxt.idx           = '0;
              st_nxt.comments_left = '0;
            end
          end else begin
            st_nxt.comment_rem = len_le;
            st_nxt.phase       = PH_VENDOR;
          end
        end
      end
      PH_VENDOR: begin
        st_nxt.block_rem   = br_dec;
        st_nxt.comment_rem = cr_dec;
        if (cr_dec == 32'd0) begin
          if (br_dec < 24'd4) begin
            emit = 1'b1;
          end else begin
            st_nxt.phase         = PH_COUNT;
            st_nxt.idx           = '0;
            st_nxt.comments_left = '0;
          end
        end
      end
      PH_COUNT: begin
        st_nxt.block_rem     = br_dec;
        st_nxt.comments_left = cnt_le;
        st_nxt.idx           = idx_inc;
        if (cur.idx[1:0] == 2'd3) begin
          if ((cnt_le == 32'd0) || (br_dec < 24'd4)) begin
            emit = 1'b1;
          end else begin
            st_nxt.phase   = PH_CLEN;
            st_nxt.idx     = '0;
            st_nxt.len_acc = '0;
          end
        end
      end
      PH_CLEN: begin
        st_nxt.block_rem = br_dec;
        st_nxt.len_acc   = len_le;
        st_nxt.idx       = idx_inc;
        if (cur.idx[1:0] == 2'd3) begin
          if (len_le > {8'd0, br_dec}) begin
            emit = 1'b1;
          end else begin
            st_nxt.comments_left = cur.comments_left - 32'd1;
            st_nxt.comment_rem   = len_le;
            st_nxt.key_match     = (len_le >= 32'(KEY_LEN));
            st_nxt.idx           = '0;
            st_nxt.val_sign      = 1'b0;
            st_nxt.val_acc       = '0;
            st_nxt.frac_seen     = '0;
            if (len_le == 32'd0) begin
              // An empty comment ends at once and cannot carry the key.
              if ((cur.comments_left == 32'd1) || (br_dec < 24'd4)) begin
                emit = 1'b1;
              end else begin
                st_nxt.phase   = PH_CLEN;
                st_nxt.idx     = '0;
                st_nxt.len_acc = '0;
              end
            end else if (len_le >= 32'(KEY_LEN)) begin
              st_nxt.phase = PH_KEY;
            end else begin
              st_nxt.phase = PH_VSTOP;
            end
          end
        end
      end
      PH_KEY, PH_VLEAD, PH_VSIGN, PH_VINT, PH_VFRAC, PH_VSTOP: begin
        st_nxt.block_rem   = br_dec;
        st_nxt.comment_rem = cr_dec;
        unique case (cur.phase)
          PH_KEY: begin
            if (!k_hit) begin
              st_nxt.key_match = 1'b0;
              st_nxt.phase     = PH_VSTOP;
            end else begin
              st_nxt.idx = idx_inc;
              if (idx_inc >= KEY_LEN) begin
                st_nxt.phase = PH_VLEAD;
              end
            end
          end
          PH_VLEAD: begin
            if (ws) begin
              st_nxt.phase = PH_VLEAD;
            end else if ((b == "+") || (b == "-")) begin
              st_nxt.val_sign = (b == "-");
              st_nxt.phase    = PH_VSIGN;
            end else begin
              st_nxt.val_acc = num_acc;
              st_nxt.phase   = num_phase;
            end
          end
          PH_VSIGN, PH_VINT: begin
            st_nxt.val_acc = num_acc;
            st_nxt.phase   = num_phase;
          end
          PH_VFRAC: begin
            if (!digit) begin
              st_nxt.phase = PH_VSTOP;
            end else if (!cur.frac_seen[1]) begin
              st_nxt.val_acc   = frac_sat;
              st_nxt.frac_seen = cur.frac_seen + 2'd1;
            end
          end
          default: begin
            st_nxt.phase = cur.phase;
          end
        endcase
        if (cr_dec == 32'd0) begin
          // The comment is complete: keep its value if the whole key matched.
          if (st_nxt.key_match && (st_nxt.phase != PH_KEY)) begin
            gain_mag          = {1'b0, st_nxt.val_acc};
            st_nxt.kept_gain  = st_nxt.val_sign ? (16'd0 - gain_mag) : gain_mag;
            st_nxt.kept_found = 1'b1;
          end
          if ((cur.comments_left == 32'd0) || (br_dec < 24'd4)) begin
            emit = 1'b1;
          end else begin
            st_nxt.phase   = PH_CLEN;
            st_nxt.idx     = '0;
            st_nxt.len_acc = '0;
          end
        end
      end
      default: begin
        st_nxt = cur;
      end
    endcase
    if (!emit && hold.last && (st_nxt.phase != PH_IDLE) && (st_nxt.phase != PH_DONE)) begin
      emit   = 1'b1;
      reason = REASON_TRUNCATED;
    end
    if (emit) begin
      st_nxt.phase = PH_DONE;
    end
  end

  // The all-zero state is the idle phase with every counter cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= st_nxt;
    end
  end

  assign status = '{emit: hold.valid && emit, phase: state_r.phase};

  assign result.gain   = (reason == REASON_DONE) ? st_nxt.kept_gain : 16'sd0;
  assign result.found  = (reason == REASON_DONE) ? st_nxt.kept_found : 1'b0;
  assign result.reason = reason;

endmodule

// ===== rtl/core/frgts_out_reg.sv =====
// Result register that drives the output stream.
`timescale 1ns / 1ps

module frgts_out_reg
  import frgts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // gain_centi_db
  output logic [2:0]  out_tuser   // tag_found, end_reason
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.gain;
  assign out_tuser  = {data_r.reason, data_r.found};

endmodule

// ===== rtl/core/flac_replaygain_tag_scanner.sv =====
// Top level of the FLAC replay gain tag scanner.
// The block takes a FLAC file as a stream of bytes, one item per byte, with
// in_tuser marking the first byte of a file and in_tlast its last byte. It
// checks the marker, skips metadata blocks up to the Vorbis comment block,
// and parses the last REPLAYGAIN_TRACK_GAIN= comment (any letter case) into
// signed hundredths of a dB, saturated at 32767 in magnitude. At most one
// result item comes per file that starts with a first byte, when the scan
// ends: on the comment block's end, on the last block, on a bad marker or on
// a truncated stream; bytes after that are dropped until the next first byte.
// Throughput is one byte per clock cycle unless the input stalls; the parser
// updates the scan state once per byte, and a result is formed from the held
// byte that ends the scan and registered in the result register. Input stalls
// only while a result item is waiting and the held byte would end a scan.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flac_replaygain_tag_scanner
  import frgts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // gain_centi_db
  output logic [2:0]  out_tuser   // tag_found, end_reason
);

  hold_t         hold;
  parse_status_t status;
  result_t       result;
  logic          out_free;
  logic          advance;
  logic          load;

  // A held byte moves on unless its result would overwrite a waiting one.
  assign advance = hold.valid && (out_free || !status.emit);
  assign load    = advance && status.emit;

  frgts_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .hold      (hold)
  );

  frgts_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold    (hold),
    .advance (advance),
    .status  (status),
    .result  (result)
  );

  frgts_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `FRGTS_ASSERT_IMP(a_no_overwrite, load, out_free, "result loaded over a waiting item")
  `FRGTS_ASSERT_NXT(a_done_after_emit, load, status.phase == PH_DONE, "scan not done after result")
  `FRGTS_ASSERT_IMP(a_quiet_when_idle, advance && !hold.first && ((status.phase == PH_IDLE) || (status.phase == PH_DONE)), !status.emit, "result without a running scan")
  `FRGTS_ASSERT_IMP(a_zero_on_failure, out_tvalid && (out_tuser[2:1] != REASON_DONE), (out_tdata == 16'd0) && !out_tuser[0], "gain reported on a failed scan")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for the FLAC replay gain tag scanner: directed and random byte streams.
`timescale 1ns / 1ps

import frgts_pkg::*;

// Tracks the scan of the byte stream and keeps the result items still owed by the block.
class gain_tag_checker;
  localparam bit [31:0]  MARKER_TEXT = "fLaC";
  localparam bit [175:0] KEY_TEXT = "REPLAYGAIN_TRACK_GAIN=";
  localparam int unsigned KEY_BYTES = 22;
  localparam int unsigned GAIN_SAT = 32767;

  phase_t      phase;
  int unsigned idx;
  bit          last_blk;
  bit [31:0]   blk_rem;
  bit [31:0]   len_acc;
  bit [31:0]   cmts_left;
  bit [31:0]   cmt_rem;
  bit          key_ok;
  bit          neg;
  int unsigned val;
  int unsigned frac;
  bit [15:0]   kept_gain;
  bit          kept_found;
  bit          fired;

  result_t     pending_results[$];
  int unsigned errors;
  int unsigned bytes_used;
  int unsigned results_due;
  int unsigned results_seen;
  int unsigned tags_seen;
  int unsigned reason_hits[4];

  function new();
    phase = PH_IDLE;
    clear();
  endfunction

  function void clear();
    idx = 0;
    last_blk = 0;
    blk_rem = 0;
    len_acc = 0;
    cmts_left = 0;
    cmt_rem = 0;
    key_ok = 0;
    neg = 0;
    val = 0;
    frac = 0;
    kept_gain = 0;
    kept_found = 0;
  endfunction

  function void finish_scan(logic [1:0] why);
    result_t r;
    r.gain = (why == REASON_DONE) ? kept_gain : 16'd0;
    r.found = (why == REASON_DONE) ? kept_found : 1'b0;
    r.reason = why;
    pending_results.push_back(r);
    results_due++;
    phase = PH_DONE;
    fired = 1;
  endfunction

  function void open_count();
    if (blk_rem < 4) begin
      finish_scan(REASON_DONE);
    end else begin
      phase = PH_COUNT;
      idx = 0;
      cmts_left = 0;
    end
  endfunction

  function void next_comment();
    if (cmts_left == 0 || blk_rem < 4) begin
      finish_scan(REASON_DONE);
    end else begin
      phase = PH_CLEN;
      idx = 0;
      len_acc = 0;
    end
  endfunction

  function void close_comment();
    // Only a comment whose full key matched reaches the value phases with key_ok set.
    if (key_ok && phase >= PH_VLEAD && phase <= PH_VSTOP) begin
      kept_gain = neg ? (16'd0 - val[15:0]) : val[15:0];
      kept_found = 1;
    end
    next_comment();
  endfunction

  function void number_byte(logic [7:0] b);
    int unsigned v;
    if (b >= "0" && b <= "9") begin
      v = val * 10 + 100 * (b - 8'h30);
      val = (v > GAIN_SAT) ? GAIN_SAT : v;
      phase = PH_VINT;
    end else if (b == ".") begin
      phase = PH_VFRAC;
    end else begin
      phase = PH_VSTOP;
    end
  endfunction

  function void fraction_byte(logic [7:0] b);
    int unsigned v;
    if (!(b >= "0" && b <= "9")) begin
      phase = PH_VSTOP;
    end else if (frac < 2) begin
      v = val + ((frac == 0) ? 10 * (b - 8'h30) : (b - 8'h30));
      val = (v > GAIN_SAT) ? GAIN_SAT : v;
      frac++;
    end
  endfunction

  function void comment_byte(logic [7:0] b);
    logic [7:0] k;
    bit hit;
    blk_rem--;
    cmt_rem--;
    case (phase)
      PH_KEY: begin
        k = KEY_TEXT[8 * (KEY_BYTES - 1 - idx) +: 8];
        hit = (b == k) || (k >= "A" && k <= "Z" && b == k + 8'd32);
        if (!hit) begin
          key_ok = 0;
          phase = PH_VSTOP;
        end else begin
          idx++;
          if (idx >= KEY_BYTES) phase = PH_VLEAD;
        end
      end
      PH_VLEAD: begin
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
          // Leading white space is skipped.
        end else if (b == "+" || b == "-") begin
          neg = (b == "-");
          phase = PH_VSIGN;
        end else begin
          number_byte(b);
        end
      end
      PH_VSIGN, PH_VINT: number_byte(b);
      PH_VFRAC: fraction_byte(b);
      default: ;
    endcase
    if (cmt_rem == 0) close_comment();
  endfunction

  // Notes one accepted input item and queues the result it causes, if any.
  function void take_byte(logic [7:0] b, bit first, bit last);
    fired = 0;
    if (first) begin
      clear();
      phase = PH_MARKER;
    end
    if (phase != PH_IDLE && phase != PH_DONE) bytes_used++;
    case (phase)
      PH_MARKER: begin
        if (b != MARKER_TEXT[8 * (3 - (idx & 3)) +: 8]) begin
          finish_scan(REASON_BAD_MARKER);
        end else begin
          idx++;
          if (idx >= 4) begin
            phase = PH_HEADER;
            idx = 0;
            len_acc = 0;
          end
        end
      end
      PH_HEADER: begin
        len_acc = {len_acc[23:0], b};
        idx++;
        if (idx >= 4) begin
          last_blk = len_acc[31];
          blk_rem = {8'd0, len_acc[23:0]};
          idx = 0;
          if (len_acc[30:24] == VORBIS_COMMENT_TYPE) begin
            if (blk_rem < 4) finish_scan(REASON_DONE);
            else phase = PH_VLEN;
          end else if (blk_rem == 0) begin
            if (last_blk) finish_scan(REASON_NO_COMMENT);
          end else begin
            phase = PH_SKIP;
          end
          len_acc = 0;
        end
      end
      PH_SKIP: begin
        blk_rem--;
        if (blk_rem == 0) begin
          if (last_blk) begin
            finish_scan(REASON_NO_COMMENT);
          end else begin
            phase = PH_HEADER;
            idx = 0;
            len_acc = 0;
          end
        end
      end
      PH_VLEN: begin
        blk_rem--;
        len_acc = len_acc | ({24'd0, b} << (8 * (idx & 3)));
        idx++;
        if (idx >= 4) begin
          if (len_acc > blk_rem) begin
            finish_scan(REASON_DONE);
          end else if (len_acc == 0) begin
            open_count();
          end else begin
            cmt_rem = len_acc;
            phase = PH_VENDOR;
          end
        end
      end
      PH_VENDOR: begin
        blk_rem--;
        cmt_rem--;
        if (cmt_rem == 0) open_count();
      end
      PH_COUNT: begin
        blk_rem--;
        cmts_left = cmts_left | ({24'd0, b} << (8 * (idx & 3)));
        idx++;
        if (idx >= 4) next_comment();
      end
      PH_CLEN: begin
        blk_rem--;
        len_acc = len_acc | ({24'd0, b} << (8 * (idx & 3)));
        idx++;
        if (idx >= 4) begin
          if (len_acc > blk_rem) begin
            finish_scan(REASON_DONE);
          end else begin
            cmts_left--;
            cmt_rem = len_acc;
            key_ok = (len_acc >= KEY_BYTES);
            idx = 0;
            neg = 0;
            val = 0;
            frac = 0;
            if (len_acc == 0) close_comment();
            else phase = key_ok ? PH_KEY : PH_VSTOP;
          end
        end
      end
      PH_KEY, PH_VLEAD, PH_VSIGN, PH_VINT, PH_VFRAC, PH_VSTOP: comment_byte(b);
      default: return;
    endcase
    if (!fired && last && phase != PH_IDLE && phase != PH_DONE)
      finish_scan(REASON_TRUNCATED);
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(logic [15:0] gain, logic found, logic [1:0] why);
    result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result item with none expected: gain %0d found %0b reason %0d",
                       $signed(gain), found, why));
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    reason_hits[want.reason]++;
    if (want.found) tags_seen++;
    if (gain !== want.gain)
      report($sformatf("gain %0d, expected %0d", $signed(gain), want.gain));
    if (found !== want.found)
      report($sformatf("tag_found %0b, expected %0b", found, want.found));
    if (why !== want.reason)
      report($sformatf("end_reason %0d, expected %0d", why, want.reason));
  endtask
endclass

module tb;
  localparam int LIMIT = 400000;
  localparam int RANDOM_BYTES = 800;
  localparam int MIN_RESULTS = 8;
  localparam logic [6:0] BLOCK_STREAMINFO = 7'd0;
  localparam logic [6:0] BLOCK_PADDING = 7'd1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  int unsigned in_idle_pct = 12;
  int unsigned out_stall_pct = 12;
  int unsigned cycles = 0;
  int unsigned files = 0;
  logic [7:0]  fb[$];
  gain_tag_checker sb;

  flac_replaygain_tag_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  // out_tuser carries tag_found in bit 0 and end_reason above it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser[0], out_tuser[2:1]);
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input bit first, input bit last);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b, first, last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic put8(input logic [7:0] b);
    fb.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) fb.push_back(s[i]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) fb.push_back(v[8 * i +: 8]);
  endtask

  task automatic set_le32(input int pos, input logic [31:0] v);
    for (int i = 0; i < 4; i++) fb[pos + i] = v[8 * i +: 8];
  endtask

  task automatic put_header(input bit last, input logic [6:0] kind, input logic [23:0] len);
    fb.push_back({last, kind});
    fb.push_back(len[23:16]);
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
  endtask

  task automatic close_block(input int hp);
    logic [23:0] len;
    len = 24'(fb.size() - hp - 4);
    fb[hp + 1] = len[23:16];
    fb[hp + 2] = len[15:8];
    fb[hp + 3] = len[7:0];
  endtask

  task automatic put_comment(input string s);
    put_le32(s.len());
    put_text(s);
  endtask

  task automatic trim_to(input int n);
    while (fb.size() > n) void'(fb.pop_back());
  endtask

  task automatic send_file(input bit mark_end);
    for (int i = 0; i < fb.size(); i++)
      send_item(fb[i], i == 0, mark_end && (i == fb.size() - 1));
    fb.delete();
    files++;
  endtask

  // A file whose comment block is the last block and holds exactly two comments.
  task automatic tag_file(input string c0, input string c1);
    int hp;
    put_text("fLaC");
    put_header(1'b0, BLOCK_PADDING, 24'd2);
    put8(8'h00);
    put8(8'hFF);
    hp = fb.size();
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd0);
    put_comment("vendor");
    put_le32(2);
    put_comment(c0);
    put_comment(c1);
    close_block(hp);
    send_file(1'b1);
  endtask

  task automatic directed_files();
    int hp;
    string filler;
    // Bytes before any first byte are dropped, stream_end included.
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);

    // Stream info, then the comment block; audio bytes after the scan end are dropped.
    put_text("fLaC");
    put_header(1'b0, BLOCK_STREAMINFO, 24'd3);
    put_text("abc");
    hp = fb.size();
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd0);
    put_comment("vendor");
    put_le32(2);
    put_comment("TITLE=x");
    put_comment("REPLAYGAIN_TRACK_GAIN=-6.52 dB");
    close_block(hp);
    put_text("xy");
    send_file(1'b1);

    tag_file("rePlaYgain_tRack_gaiN= \t+3.14159", "");
    tag_file("REPLAYGAIN_TRACK_GAIN=99999.99", "ARTIST=somebody");
    tag_file("REPLAYGAIN_TRACK_GAIN=-400.00", "");
    tag_file("ReplayGain_Track_Gain=1.5", "REPLAYGAIN_TRACK_GAIN=-0.05");
    tag_file("REPLAYGAIN_TRACK_GAIN=abc", "REPLAYGAIN_ALBUM_GAIN=-9.00");
    tag_file("REPLAYGAIN_TRACK_GAIN=1e5", "REPLAYGAIN_TRACK_GAIN");
    tag_file("REPLAYGAIN_TRACK_GAIN=-.5", "REPLAYGAIN");
    tag_file("REPLAYGAIN_ALBUM_GAIN=-9.00", "REPLAYGAIN_TRACK_GAIN=");

    // The value ends where the comment ends; the next length byte is the digit 5.
    filler = "";
    repeat (53) filler = {filler, "x"};
    tag_file("REPLAYGAIN_TRACK_GAIN=-1", filler);

    // Bad marker at its last and at its first byte.
    put_text("fLaX");
    send_file(1'b1);
    put_text("FLaC");
    send_file(1'b1);

    // Last block is not a comment block.
    put_text("fLaC");
    put_header(1'b1, BLOCK_STREAMINFO, 24'd4);
    put_text("abcd");
    send_file(1'b1);
    put_text("fLaC");
    put_header(1'b0, 7'h7F, 24'd0);
    put_header(1'b1, BLOCK_PADDING, 24'd0);
    send_file(1'b1);

    // Truncated inside a block of the largest length.
    put_text("fLaC");
    put_header(1'b0, BLOCK_STREAMINFO, 24'hFFFFFF);
    put_text("ab");
    send_file(1'b1);

    // Abandoned without stream_end; the next first byte restarts the scan.
    put_text("fLaC");
    put_header(1'b0, BLOCK_STREAMINFO, 24'd10);
    put_text("ab");
    send_file(1'b0);

    // Comment block too short to hold a vendor length.
    put_text("fLaC");
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd3);
    put_text("abc");
    send_file(1'b1);

    // Vendor string longer than the block.
    put_text("fLaC");
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd8);
    put_le32(32'hFFFFFFFF);
    put_le32(0);
    send_file(1'b1);

    // Fewer than four bytes left for the comment count.
    put_text("fLaC");
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd9);
    put_comment("abc");
    put_text("zz");
    send_file(1'b1);

    // Empty vendor string and no comments.
    put_text("fLaC");
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd8);
    put_le32(0);
    put_le32(0);
    send_file(1'b1);

    // Count larger than the block holds: the block end stops the scan with the gain.
    put_text("fLaC");
    hp = fb.size();
    put_header(1'b0, VORBIS_COMMENT_TYPE, 24'd0);
    put_comment("v");
    put_le32(32'hFFFFFFFF);
    put_comment("REPLAYGAIN_TRACK_GAIN=+12.34");
    close_block(hp);
    put_text("zz");
    send_file(1'b1);

    // Comment length beyond the block after a matched comment.
    put_text("fLaC");
    hp = fb.size();
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd0);
    put_comment("v");
    put_le32(2);
    put_comment("REPLAYGAIN_TRACK_GAIN=2");
    put_le32(32'hFFFFFFFF);
    close_block(hp);
    send_file(1'b1);

    // Empty vendor and an empty comment ahead of the tag.
    put_text("fLaC");
    hp = fb.size();
    put_header(1'b1, VORBIS_COMMENT_TYPE, 24'd0);
    put_le32(0);
    put_le32(2);
    put_le32(0);
    put_comment("REPLAYGAIN_TRACK_GAIN=7");
    close_block(hp);
    send_file(1'b1);
  endtask

  task automatic add_gain_text();
    string key;
    logic [7:0] c;
    int pos;
    key = "REPLAYGAIN_TRACK_GAIN=";
    pos = fb.size();
    for (int i = 0; i < 22; i++) begin
      c = key[i];
      if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
      put8(c);
    end
    if ($urandom_range(99) < 6) fb[pos + $urandom_range(21)] = 8'($urandom);
    repeat ($urandom_range(2))
      put8(($urandom_range(5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(4)));
    case ($urandom_range(2))
      1: put8("+");
      2: put8("-");
      default: ;
    endcase
    repeat ($urandom_range(($urandom_range(3) == 0) ? 6 : 3))
      put8(8'(8'h30 + $urandom_range(9)));
    if ($urandom_range(9) < 7) begin
      put8(".");
      repeat ($urandom_range(4)) put8(8'(8'h30 + $urandom_range(9)));
    end
    case ($urandom_range(9))
      0, 1, 2: put_text(" dB");
      3: put8(8'($urandom));
      4: put_text("e2");
      default: ;
    endcase
  endtask

  task automatic add_skip_block(input bit last);
    int hp;
    logic [6:0] kind;
    kind = 7'($urandom_range(127));
    if (kind == VORBIS_COMMENT_TYPE) kind = BLOCK_PADDING;
    hp = fb.size();
    put_header(last, kind, 24'd0);
    repeat ($urandom_range(($urandom_range(3) == 0) ? 12 : 3)) put8(8'($urandom));
    close_block(hp);
  endtask

  task automatic add_comment_block(input bit last);
    int hp;
    int cp;
    int n;
    logic [23:0] len;
    hp = fb.size();
    put_header(last, VORBIS_COMMENT_TYPE, 24'd0);
    cp = fb.size();
    put_le32(0);
    repeat ($urandom_range(8)) put8(8'($urandom_range(126, 32)));
    set_le32(cp, fb.size() - cp - 4);
    n = $urandom_range(4);
    case ($urandom_range(19))
      0: put_le32($urandom);
      1: put_le32(n + 1);
      default: put_le32(n);
    endcase
    repeat (n) begin
      cp = fb.size();
      put_le32(0);
      if ($urandom_range(9) < 6) add_gain_text();
      else repeat ($urandom_range($urandom_range(1) ? 30 : 6)) put8(8'($urandom));
      if ($urandom_range(9) == 0) trim_to(cp + 4 + $urandom_range(fb.size() - cp - 4));
      set_le32(cp, fb.size() - cp - 4);
    end
    repeat ($urandom_range(3)) put8(8'($urandom));
    close_block(hp);
    // Now and then the block claims a random length up to the bytes it carries.
    if ($urandom_range(19) == 0) begin
      len = 24'($urandom_range(fb.size() - hp - 4));
      fb[hp + 1] = len[23:16];
      fb[hp + 2] = len[15:8];
      fb[hp + 3] = len[7:0];
    end
  endtask

  task automatic build_random_file(output bit mark_end);
    int r;
    int nskip;
    bit no_cmt;
    r = $urandom_range(99);
    if (r < 6) begin
      repeat (1 + $urandom_range(10)) put8(8'($urandom));
      if ($urandom_range(1)) fb[0] = "f";
    end else begin
      put_text("fLaC");
      nskip = $urandom_range(2);
      no_cmt = ($urandom_range(99) < 10);
      if (no_cmt && nskip == 0) nskip = 1;
      for (int i = 0; i < nskip; i++) add_skip_block(no_cmt && i == nskip - 1);
      if (!no_cmt) add_comment_block($urandom_range(1));
      repeat ($urandom_range(4)) put8(8'($urandom));
      if (r < 20) repeat (1 + $urandom_range(1)) fb[$urandom_range(fb.size() - 1)] = 8'($urandom);
      else if (r < 32) trim_to(1 + $urandom_range(fb.size() - 1));
    end
    mark_end = ($urandom_range(9) != 0);
  endtask

  initial begin
    int unsigned used0;
    int unsigned due0;
    int nfile;
    bit mark_end;
    bit quiet;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_files();
    wait_drained();

    used0 = sb.bytes_used;
    due0 = sb.results_due;
    nfile = 0;
    while (sb.bytes_used - used0 < RANDOM_BYTES || sb.results_due - due0 < MIN_RESULTS) begin
      quiet = (nfile >= 3 && nfile < 9);
      in_idle_pct = quiet ? 0 : 12;
      out_stall_pct = quiet ? 0 : 12;
      // Stray items without a first byte.
      if ($urandom_range(99) < 3)
        repeat (1 + $urandom_range(3)) send_item(8'($urandom), 1'b0, 1'($urandom_range(1)));
      build_random_file(mark_end);
      send_file(mark_end);
      if ($urandom_range(99) < 5) wait_drained();
      nfile++;
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("Scanned %0d files, %0d bytes in live scans, %0d result items checked.",
             files, sb.bytes_used, sb.results_seen);
    $display("End reasons: done %0d, no comment block %0d, bad marker %0d, truncated %0d;"
             , sb.reason_hits[REASON_DONE], sb.reason_hits[REASON_NO_COMMENT],
             sb.reason_hits[REASON_BAD_MARKER], sb.reason_hits[REASON_TRUNCATED]);
    $display("  track gain tags found in %0d results.", sb.tags_seen);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/frgts_pkg.sv
rtl/core/frgts_in_reg.sv
rtl/core/frgts_parser.sv
rtl/core/frgts_out_reg.sv
rtl/core/flac_replaygain_tag_scanner.sv
tb/sv/tb.sv
